// ===== rtl/tgarle_pkg.sv =====
// Shared types and constants for the TGA run-length image decoder.
// Holds the result beat layout, result kinds and the divider interface.
// No dependencies.
package tgarle_pkg;

	localparam logic [1:0] KIND_HEADER     = 2'd0;
	localparam logic [1:0] KIND_SPAN       = 2'd1;
	localparam logic [1:0] KIND_BAD_TYPE   = 2'd2;
	localparam logic [1:0] KIND_BAD_FORMAT = 2'd3;

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] BPP_24   = 8'd24;
	localparam logic [7:0] BPP_32   = 8'd32;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	localparam int DIV_STEPS       = 3;
	localparam int DIV_DIGIT_BITS  = 3;
	localparam int DIV_QUOT_BITS   = DIV_STEPS * DIV_DIGIT_BITS;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] start_row;
		logic [15:0] start_column;
		logic [7:0]  span_length;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        image_done;
	} result_t;

	typedef struct packed {
		logic        start;
		logic        cancel;
		logic [16:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic [DIV_QUOT_BITS-1:0] quotient;
		logic [15:0]              remainder;
	} div_rsp_t;

endpackage

// ===== rtl/tga_rle_image_decoder.sv =====
// Top level of the TGA 24/32-bit raw and run-length image decoder.
// Instantiates tgarle_parse, tgarle_div and tgarle_skid; uses tgarle_pkg.
//
// Input channel: one file byte per beat on data_byte, start_of_image high on
// header byte 0 (restarts any decode in progress). Output channel: one result
// beat per header verdict (kind, image_width, image_height) and per pixel span
// (colour, start_row, start_column, span_length), image_done on the last one.
// Spans start at row height-1, column 0 and continue in raster order upward.
// Throughput: one byte per cycle while in_stall is low. A result is registered
// into the output register, or into the skid entry while the receiver stalls,
// once the byte that completes it is accepted. After a multi-pixel run the
// position is updated by a radix-8 divider; the colour byte that completes a
// following span is held on in_stall while that divider is still busy.
// The output side has a result register plus one skid entry, so a stalled
// receiver lets one more result be produced before in_stall rises.
// Reset: parser idle awaiting start_of_image, no result pending.
module tga_rle_image_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_image,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [15:0] start_row,
	output logic [15:0] start_column,
	output logic [7:0]  span_length,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        image_done
);

	logic                 accept;
	logic                 hold;
	logic                 full;
	logic                 res_valid;
	tgarle_pkg::result_t  res;
	tgarle_pkg::result_t  out_res;
	tgarle_pkg::div_req_t div_req;
	tgarle_pkg::div_rsp_t div_rsp;

	assign in_stall = full || hold;
	assign accept   = in_valid && !in_stall;

	tgarle_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (data_byte),
		.start_of_image (start_of_image),
		.div_rsp        (div_rsp),
		.div_req        (div_req),
		.res_valid      (res_valid),
		.res            (res),
		.hold           (hold)
	);

	tgarle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tgarle_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (full)
	);

	assign kind         = out_res.kind;
	assign red          = out_res.red;
	assign green        = out_res.green;
	assign blue         = out_res.blue;
	assign alpha        = out_res.alpha;
	assign start_row    = out_res.start_row;
	assign start_column = out_res.start_column;
	assign span_length  = out_res.span_length;
	assign image_width  = out_res.image_width;
	assign image_height = out_res.image_height;
	assign image_done   = out_res.image_done;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> out_valid)
		else $error("skid entry filled while output register empty");

	a_span_not_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.kind == tgarle_pkg::KIND_SPAN)) |-> !div_rsp.busy)
		else $error("span produced while position update in flight");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && image_done) |->
			(kind == tgarle_pkg::KIND_HEADER || kind == tgarle_pkg::KIND_SPAN))
		else $error("image_done on a rejection beat");

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == tgarle_pkg::KIND_SPAN)) |-> (span_length != 8'd0))
		else $error("empty span delivered");

endmodule

// ===== rtl/tgarle_div.sv =====
// Radix-8 restoring divider for the span position update.
// Produces three quotient digits; quotient is known to fit nine bits.
// Depends on tgarle_pkg.
module tgarle_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tgarle_pkg::div_req_t req,
	output tgarle_pkg::div_rsp_t rsp
);

	localparam int RemW = 16 + tgarle_pkg::DIV_DIGIT_BITS;
	localparam int LowW = tgarle_pkg::DIV_QUOT_BITS;
	localparam int DigN = 2 ** tgarle_pkg::DIV_DIGIT_BITS;

	logic                   busy_q;
	logic [1:0]             step_q;
	logic [15:0]            rem_q;
	logic [15:0]            dsr_q;
	logic [LowW-1:0]        low_q;
	logic [LowW-tgarle_pkg::DIV_DIGIT_BITS-1:0] quo_q;

	logic [RemW-1:0]        rem_ext;
	logic [RemW-1:0]        mult [DigN];
	logic [tgarle_pkg::DIV_DIGIT_BITS-1:0] digit;
	logic [RemW-1:0]        rem_next;
	logic                   last_step;

	assign rem_ext   = {rem_q, low_q[LowW-1 -: tgarle_pkg::DIV_DIGIT_BITS]};
	assign last_step = (step_q == 2'(tgarle_pkg::DIV_STEPS - 1));

	always_comb begin
		for (int k = 0; k < DigN; k++) begin
			mult[k] = RemW'(dsr_q) * RemW'(k);
		end
		digit = '0;
		for (int k = 1; k < DigN; k++) begin
			if (rem_ext >= mult[k]) begin
				digit = tgarle_pkg::DIV_DIGIT_BITS'(k);
			end
		end
		rem_next = rem_ext - mult[digit];
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = busy_q && last_step;
	assign rsp.quotient  = {quo_q, digit};
	assign rsp.remainder = rem_next[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			low_q  <= '0;
			quo_q  <= '0;
		end else if (req.cancel) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= '0;
			rem_q  <= 16'(req.dividend[16:LowW]);
			low_q  <= req.dividend[LowW-1:0];
			dsr_q  <= req.divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			rem_q  <= rem_next[15:0];
			low_q  <= low_q << tgarle_pkg::DIV_DIGIT_BITS;
			quo_q  <= {quo_q[LowW-2*tgarle_pkg::DIV_DIGIT_BITS-1:0], digit};
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/tgarle_parse.sv =====
// Header parser, packet decoder and pixel position tracker.
// Turns one accepted file byte into at most one result beat.
// Depends on tgarle_pkg.
module tgarle_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 start_of_image,
	input  tgarle_pkg::div_rsp_t div_rsp,
	output tgarle_pkg::div_req_t div_req,
	output logic                 res_valid,
	output tgarle_pkg::result_t  res,
	output logic                 hold
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_IDSKIP,
		PH_PKTHDR,
		PH_PIXEL
	} phase_t;

	localparam logic [4:0] HDR_ID_LEN    = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_BPP       = 5'd16;
	localparam logic [4:0] HDR_LAST      = 5'd17;

	phase_t      phase_q;
	logic [4:0]  hdr_cnt_q;
	logic [7:0]  type_q;
	logic [7:0]  cmap_q;
	logic [7:0]  bpp_q;
	logic [7:0]  id_left_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  pkt_left_q;
	logic        pkt_run_q;
	logic [1:0]  cidx_q;
	logic [7:0]  c0_q;
	logic [7:0]  c1_q;
	logic [7:0]  c2_q;
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [31:0] pix_left_q;

	phase_t      ph;
	logic [4:0]  cnt;
	logic        hdr_last;
	logic        bad_type;
	logic        bad_fmt;
	logic        empty;
	logic        rle;
	logic        need32;
	logic        pix_last;
	logic [7:0]  run_len;
	logic        clip;
	logic [7:0]  span_len;
	logic        begin_pix;
	logic        hdr_out;
	logic        pix_out;

	always_comb begin
		ph       = start_of_image ? PH_HEADER : phase_q;
		cnt      = start_of_image ? '0 : hdr_cnt_q;
		hdr_last = (cnt == HDR_LAST);
		bad_type = (type_q != tgarle_pkg::TYPE_RAW) && (type_q != tgarle_pkg::TYPE_RLE);
		bad_fmt  = (cmap_q != 8'd0) ||
		           ((bpp_q != tgarle_pkg::BPP_24) && (bpp_q != tgarle_pkg::BPP_32));
		empty    = (width_q == 16'd0) || (height_q == 16'd0);
		rle      = (type_q == tgarle_pkg::TYPE_RLE);
		need32   = (bpp_q == tgarle_pkg::BPP_32);
		pix_last = (cidx_q == (need32 ? 2'd3 : 2'd2));
		run_len  = (rle && pkt_run_q) ? pkt_left_q : 8'd1;
		clip     = (32'(run_len) >= pix_left_q);
		span_len = clip ? pix_left_q[7:0] : run_len;
		hdr_out  = accept && (ph == PH_HEADER) && hdr_last;
		pix_out  = accept && (ph == PH_PIXEL) && pix_last;
		begin_pix = (hdr_out && !bad_type && !bad_fmt && !empty && (id_left_q == 8'd0)) ||
		            (accept && (ph == PH_IDSKIP) && (id_left_q == 8'd1));
	end

	assign res_valid = hdr_out || pix_out;
	assign hold      = div_rsp.busy && (phase_q == PH_PIXEL) && pix_last;

	assign div_req.start    = pix_out && !clip && (run_len != 8'd1);
	assign div_req.cancel   = accept && start_of_image;
	assign div_req.dividend = 17'(col_q) + 17'(run_len);
	assign div_req.divisor  = width_q;

	always_comb begin
		res = '0;
		if (pix_out) begin
			res.kind         = tgarle_pkg::KIND_SPAN;
			res.red          = need32 ? c2_q : data_byte;
			res.green        = c1_q;
			res.blue         = c0_q;
			res.alpha        = need32 ? data_byte : tgarle_pkg::ALPHA_OPAQUE;
			res.start_row    = row_q;
			res.start_column = col_q;
			res.span_length  = span_len;
			res.image_done   = clip;
		end else if (bad_type) begin
			res.kind = tgarle_pkg::KIND_BAD_TYPE;
		end else if (bad_fmt) begin
			res.kind = tgarle_pkg::KIND_BAD_FORMAT;
		end else begin
			res.kind         = tgarle_pkg::KIND_HEADER;
			res.image_width  = width_q;
			res.image_height = height_q;
			res.image_done   = empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hdr_cnt_q  <= '0;
			type_q     <= '0;
			cmap_q     <= '0;
			bpp_q      <= '0;
			id_left_q  <= '0;
			width_q    <= '0;
			height_q   <= '0;
			pkt_left_q <= '0;
			pkt_run_q  <= 1'b0;
			cidx_q     <= '0;
			c0_q       <= '0;
			c1_q       <= '0;
			c2_q       <= '0;
			row_q      <= '0;
			col_q      <= '0;
			pix_left_q <= '0;
		end else begin
			if (div_rsp.done && !div_req.cancel) begin
				row_q <= row_q - 16'(div_rsp.quotient);
				col_q <= div_rsp.remainder;
			end
			if (accept) begin
				if (start_of_image) begin
					phase_q    <= PH_HEADER;
					type_q     <= '0;
					cmap_q     <= '0;
					bpp_q      <= '0;
					width_q    <= '0;
					height_q   <= '0;
					pkt_left_q <= '0;
					pkt_run_q  <= 1'b0;
					cidx_q     <= '0;
					row_q      <= '0;
					col_q      <= '0;
				end
				unique case (ph)
					PH_HEADER: begin
						case (cnt)
							HDR_ID_LEN:    id_left_q <= data_byte;
							HDR_CMAP_TYPE: cmap_q <= data_byte;
							HDR_IMG_TYPE:  type_q <= data_byte;
							HDR_WIDTH_LO:  width_q[7:0] <= data_byte;
							HDR_WIDTH_HI:  width_q[15:8] <= data_byte;
							HDR_HEIGHT_LO: height_q[7:0] <= data_byte;
							HDR_HEIGHT_HI: height_q[15:8] <= data_byte;
							HDR_BPP: begin
								bpp_q      <= data_byte;
								pix_left_q <= 32'(width_q) * 32'(height_q);
							end
							default: ;
						endcase
						hdr_cnt_q <= hdr_last ? '0 : cnt + 5'd1;
						if (hdr_last) begin
							if (bad_type || bad_fmt || empty) begin
								phase_q <= PH_IDLE;
							end else if (id_left_q != 8'd0) begin
								phase_q <= PH_IDSKIP;
							end
						end
					end
					PH_IDSKIP: begin
						id_left_q <= id_left_q - 8'd1;
					end
					PH_PKTHDR: begin
						pkt_left_q <= 8'(data_byte[6:0]) + 8'd1;
						pkt_run_q  <= data_byte[7];
						cidx_q     <= '0;
						phase_q    <= PH_PIXEL;
					end
					PH_PIXEL: begin
						if (!pix_last) begin
							unique case (cidx_q)
								2'd0: c0_q <= data_byte;
								2'd1: c1_q <= data_byte;
								2'd2: c2_q <= data_byte;
								2'd3: ;
							endcase
							cidx_q <= cidx_q + 2'd1;
						end else begin
							cidx_q     <= '0;
							pix_left_q <= pix_left_q - 32'(span_len);
							if (clip) begin
								phase_q    <= PH_IDLE;
								row_q      <= '0;
								col_q      <= '0;
								pkt_left_q <= '0;
							end else begin
								if (run_len == 8'd1) begin
									if (col_q + 16'd1 == width_q) begin
										col_q <= '0;
										row_q <= row_q - 16'd1;
									end else begin
										col_q <= col_q + 16'd1;
									end
								end
								if (rle) begin
									if (pkt_run_q) begin
										pkt_left_q <= '0;
										phase_q    <= PH_PKTHDR;
									end else begin
										pkt_left_q <= pkt_left_q - 8'd1;
										if (pkt_left_q == 8'd1) begin
											phase_q <= PH_PKTHDR;
										end
									end
								end
							end
						end
					end
					PH_IDLE: ;
					default: ;
				endcase
				if (begin_pix) begin
					row_q      <= height_q - 16'd1;
					col_q      <= '0;
					cidx_q     <= '0;
					pkt_left_q <= '0;
					pkt_run_q  <= 1'b0;
					phase_q    <= rle ? PH_PKTHDR : PH_PIXEL;
				end
			end
		end
	end

endmodule

// ===== rtl/tgarle_skid.sv =====
// Output register with one skid entry for result beats.
// Lets the parser take a byte while a finished beat waits downstream.
// Depends on tgarle_pkg.
module tgarle_skid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  tgarle_pkg::result_t res,
	input  logic                out_stall,
	output logic                out_valid,
	output tgarle_pkg::result_t out_res,
	output logic                full
);

	logic                out_valid_q;
	tgarle_pkg::result_t out_q;
	logic                skid_valid_q;
	tgarle_pkg::result_t skid_q;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_q       <= res;
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_q       <= res;
			skid_valid_q <= 1'b1;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for tga_rle_image_decoder: streams TGA files byte by byte with random
// sender gaps and receiver stalls, and checks every result beat against a decoder
// model kept here. Depends on tgarle_pkg and the decoder RTL.
module tb;

	localparam int unsigned ITEM_TARGET  = 1150;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int          MAX_SHOWN    = 10;

	localparam logic [4:0] HB_ID_LENGTH  = 5'd0;
	localparam logic [4:0] HB_CMAP_TYPE  = 5'd1;
	localparam logic [4:0] HB_IMAGE_TYPE = 5'd2;
	localparam logic [4:0] HB_WIDTH_LO   = 5'd12;
	localparam logic [4:0] HB_WIDTH_HI   = 5'd13;
	localparam logic [4:0] HB_HEIGHT_LO  = 5'd14;
	localparam logic [4:0] HB_HEIGHT_HI  = 5'd15;
	localparam logic [4:0] HB_DEPTH      = 5'd16;
	localparam logic [4:0] HB_LAST       = 5'd17;

	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_HEADER,
		DEC_ID_SKIP,
		DEC_PACKET,
		DEC_PIXEL
	} dec_phase_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte      = 8'd0;
	logic        start_of_image = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [15:0] start_row;
	logic [15:0] start_column;
	logic [7:0]  span_length;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        image_done;

	bit                  calm       = 1'b0;
	int unsigned         cycles     = 0;
	int unsigned         rx_wait    = 0;
	int unsigned         bytes_used = 0;
	int                  errors     = 0;
	tgarle_pkg::result_t owed_results[$];

	dec_phase_t  dec_phase;
	logic [4:0]  hdr_index;
	logic [7:0]  img_type;
	logic [7:0]  cmap_type;
	logic [7:0]  pixel_depth;
	logic [7:0]  id_left;
	logic [7:0]  pkt_left;
	logic        pkt_run;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [15:0] row;
	logic [15:0] col;
	logic [1:0]  byte_idx;
	logic [31:0] bgra;

	tga_rle_image_decoder DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.start_of_image (start_of_image),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.alpha          (alpha),
		.start_row      (start_row),
		.start_column   (start_column),
		.span_length    (span_length),
		.image_width    (image_width),
		.image_height   (image_height),
		.image_done     (image_done)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic void clear_decoder();
		dec_phase   = DEC_IDLE;
		hdr_index   = '0;
		img_type    = '0;
		cmap_type   = '0;
		pixel_depth = '0;
		id_left     = '0;
		img_w       = '0;
		img_h       = '0;
		pkt_left    = '0;
		pkt_run     = 1'b0;
		byte_idx    = '0;
		bgra        = '0;
		row         = '0;
		col         = '0;
	endfunction

	function automatic void enter_pixels();
		row       = img_h - 16'd1;
		col       = '0;
		byte_idx  = '0;
		bgra      = '0;
		pkt_left  = '0;
		pkt_run   = 1'b0;
		dec_phase = (img_type == tgarle_pkg::TYPE_RLE) ? DEC_PACKET : DEC_PIXEL;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic sos);
		tgarle_pkg::result_t r;
		logic [31:0]         len;
		logic [31:0]         left;
		logic [16:0]         pos;
		logic [2:0]          need;
		r = '0;
		if (sos) begin
			clear_decoder();
			dec_phase = DEC_HEADER;
		end
		if (dec_phase != DEC_IDLE)
			bytes_used++;
		case (dec_phase)
			DEC_HEADER: begin
				case (hdr_index)
					HB_ID_LENGTH:  id_left = b;
					HB_CMAP_TYPE:  cmap_type = b;
					HB_IMAGE_TYPE: img_type = b;
					HB_WIDTH_LO:   img_w[7:0] = b;
					HB_WIDTH_HI:   img_w[15:8] = b;
					HB_HEIGHT_LO:  img_h[7:0] = b;
					HB_HEIGHT_HI:  img_h[15:8] = b;
					HB_DEPTH:      pixel_depth = b;
					default: ;
				endcase
				if (hdr_index != HB_LAST) begin
					hdr_index = hdr_index + 5'd1;
				end else begin
					hdr_index = '0;
					dec_phase = DEC_IDLE;
					if (img_type != tgarle_pkg::TYPE_RAW
							&& img_type != tgarle_pkg::TYPE_RLE) begin
						r.kind = tgarle_pkg::KIND_BAD_TYPE;
					end else if (cmap_type != 8'd0
							|| (pixel_depth != tgarle_pkg::BPP_24
							&& pixel_depth != tgarle_pkg::BPP_32)) begin
						r.kind = tgarle_pkg::KIND_BAD_FORMAT;
					end else begin
						r.kind         = tgarle_pkg::KIND_HEADER;
						r.image_width  = img_w;
						r.image_height = img_h;
						if (img_w == 16'd0 || img_h == 16'd0)
							r.image_done = 1'b1;
						else if (id_left != 8'd0)
							dec_phase = DEC_ID_SKIP;
						else
							enter_pixels();
					end
					owed_results.push_back(r);
				end
			end
			DEC_ID_SKIP: begin
				id_left = id_left - 8'd1;
				if (id_left == 8'd0)
					enter_pixels();
			end
			DEC_PACKET: begin
				pkt_left  = {1'b0, b[6:0]} + 8'd1;
				pkt_run   = b[7];
				byte_idx  = '0;
				bgra      = '0;
				dec_phase = DEC_PIXEL;
			end
			DEC_PIXEL: begin
				need     = (pixel_depth == tgarle_pkg::BPP_32) ? 3'd4 : 3'd3;
				bgra     = bgra | ({24'd0, b} << (8 * byte_idx));
				byte_idx = byte_idx + 2'd1;
				if (byte_idx == 2'd0 || {1'b0, byte_idx} >= need) begin
					byte_idx = '0;
					len  = (img_type == tgarle_pkg::TYPE_RLE && pkt_run)
						? {24'd0, pkt_left} : 32'd1;
					left = {16'd0, row} * {16'd0, img_w} + {16'd0, img_w} - {16'd0, col};
					if (len > left)
						len = left;
					r.kind         = tgarle_pkg::KIND_SPAN;
					r.red          = bgra[23:16];
					r.green        = bgra[15:8];
					r.blue         = bgra[7:0];
					r.alpha        = (need == 3'd4) ? bgra[31:24] : tgarle_pkg::ALPHA_OPAQUE;
					r.start_row    = row;
					r.start_column = col;
					r.span_length  = len[7:0];
					r.image_done   = (len == left);
					bgra           = '0;
					owed_results.push_back(r);
					if (r.image_done) begin
						dec_phase = DEC_IDLE;
						row       = '0;
						col       = '0;
						pkt_left  = '0;
					end else begin
						pos = {1'b0, col} + len[16:0];
						row = row - 16'(pos / {1'b0, img_w});
						col = 16'(pos % {1'b0, img_w});
						if (img_type == tgarle_pkg::TYPE_RLE) begin
							pkt_left = pkt_run ? 8'd0 : pkt_left - 8'd1;
							if (pkt_left == 8'd0)
								dec_phase = DEC_PACKET;
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic string show(input tgarle_pkg::result_t r);
		return {$sformatf("kind %0d rgba %02h%02h%02h%02h row %0d col %0d",
				r.kind, r.red, r.green, r.blue, r.alpha, r.start_row, r.start_column),
			$sformatf(" len %0d size %0dx%0d done %0b",
				r.span_length, r.image_width, r.image_height, r.image_done)};
	endfunction

	function automatic void flag_result(input string what,
			input tgarle_pkg::result_t want, input tgarle_pkg::result_t got);
		errors++;
		if (errors <= MAX_SHOWN) begin
			$display("tb: %s at cycle %0d", what, cycles);
			$display("  expected %s", show(want));
			$display("  actual   %s", show(got));
		end
	endfunction

	always @(posedge clk) begin : check_results
		tgarle_pkg::result_t got;
		tgarle_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, red, green, blue, alpha, start_row, start_column, span_length,
				image_width, image_height, image_done};
			if (owed_results.size() == 0) begin
				flag_result("unexpected result", '0, got);
			end else begin
				want = owed_results.pop_front();
				if (got !== want)
					flag_result("result mismatch", want, got);
			end
		end
	end

	// hold stall for a drawn number of cycles after each result beat
	always @(posedge clk) begin : rx_side
		int unsigned hold;
		if (arst_n && out_valid && !out_stall)
			hold = calm ? 0 : $urandom_range(0, 6);
		else
			hold = (rx_wait != 0) ? rx_wait - 1 : 0;
		rx_wait   <= hold;
		out_stall <= (hold != 0);
	end

	task automatic send_beat(input logic [7:0] b, input logic sos);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		start_of_image <= sos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_byte(b, sos);
	endtask

	task automatic send_header(input logic [7:0] id_len, input logic [7:0] cmap,
			input logic [7:0] itype, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] depth);
		send_beat(id_len, 1'b1);
		send_beat(cmap, 1'b0);
		send_beat(itype, 1'b0);
		repeat (9) send_beat(8'($urandom), 1'b0);
		send_beat(w[7:0], 1'b0);
		send_beat(w[15:8], 1'b0);
		send_beat(h[7:0], 1'b0);
		send_beat(h[15:8], 1'b0);
		send_beat(depth, 1'b0);
		send_beat(8'($urandom), 1'b0);
	endtask

	task automatic send_colour(input logic [31:0] c, input logic [7:0] depth);
		send_beat(c[7:0], 1'b0);
		send_beat(c[15:8], 1'b0);
		send_beat(c[23:16], 1'b0);
		if (depth == tgarle_pkg::BPP_32)
			send_beat(c[31:24], 1'b0);
	endtask

	task automatic test_idle_bytes();
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
	endtask

	task automatic test_header_rejects();
		send_header(8'd0, 8'd0, 8'd1, 16'd4, 16'd4, tgarle_pkg::BPP_24);
		send_header(8'd0, 8'hFF, 8'hFF, 16'd4, 16'd4, 8'd16);
		send_header(8'd0, 8'd1, tgarle_pkg::TYPE_RAW, 16'd4, 16'd4, tgarle_pkg::BPP_24);
		send_header(8'd0, 8'd0, tgarle_pkg::TYPE_RLE, 16'd4, 16'd4, 8'd16);
		send_beat(8'h12, 1'b0);
	endtask

	task automatic test_empty_images();
		send_header(8'd3, 8'd0, tgarle_pkg::TYPE_RAW, 16'd0, 16'd7, tgarle_pkg::BPP_24);
		send_header(8'd0, 8'd0, tgarle_pkg::TYPE_RLE, 16'hFFFF, 16'd0, tgarle_pkg::BPP_32);
		send_beat(8'h34, 1'b0);
	endtask

	task automatic test_raw_image();
		send_header(8'd2, 8'd0, tgarle_pkg::TYPE_RAW, 16'd2, 16'd2, tgarle_pkg::BPP_32);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_colour(32'h0000_0000, tgarle_pkg::BPP_32);
		send_colour(32'hFFFF_FFFF, tgarle_pkg::BPP_32);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_beat(8'hA5, 1'b0);
	endtask

	task automatic test_rle_packets();
		send_header(8'd0, 8'd0, tgarle_pkg::TYPE_RLE, 16'd3, 16'd2, tgarle_pkg::BPP_24);
		send_beat(8'h81, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_24);
		send_beat(8'h01, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_24);
		send_colour($urandom, tgarle_pkg::BPP_24);
		// clip a full-length run at the image end
		send_beat(8'hFF, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_24);
		send_beat(8'h00, 1'b0);
	endtask

	task automatic test_raw_packet_past_end();
		send_header(8'd1, 8'd0, tgarle_pkg::TYPE_RLE, 16'd2, 16'd1, tgarle_pkg::BPP_32);
		send_beat(8'h5A, 1'b0);
		send_beat(8'h04, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_colour($urandom, tgarle_pkg::BPP_32);
	endtask

	task automatic test_restart_and_tall_runs();
		send_header(8'd0, 8'd0, tgarle_pkg::TYPE_RLE, 16'd1, 16'hFFFF, tgarle_pkg::BPP_32);
		send_beat(8'hFF, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_beat(8'hFF, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_beat(8'h00, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_32);
		send_beat(8'h85, 1'b0);
		send_beat(8'h11, 1'b0);
		send_beat(8'h22, 1'b0);
		send_header(8'd0, 8'd0, tgarle_pkg::TYPE_RAW, 16'hFFFF, 16'hFFFF,
			tgarle_pkg::BPP_24);
		send_colour($urandom, tgarle_pkg::BPP_24);
		send_colour($urandom, tgarle_pkg::BPP_24);
		send_colour($urandom, tgarle_pkg::BPP_24);
		send_beat(8'h33, 1'b0);
		send_header(8'd0, 8'd0, tgarle_pkg::TYPE_RLE, 16'd2, 16'd2, tgarle_pkg::BPP_24);
		send_beat(8'h83, 1'b0);
		send_colour($urandom, tgarle_pkg::BPP_24);
	endtask

	task automatic test_random_files();
		int          pick;
		int          pixels;
		int          n;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  id_len;
		logic [7:0]  cmap;
		logic [7:0]  itype;
		logic [7:0]  depth;
		bit          big;
		bit          cut;
		while (bytes_used < ITEM_TARGET) begin
			calm   = ($urandom_range(0, 4) == 0);
			pick   = $urandom_range(0, 99);
			itype  = $urandom_range(0, 1) ? tgarle_pkg::TYPE_RLE : tgarle_pkg::TYPE_RAW;
			depth  = $urandom_range(0, 1) ? tgarle_pkg::BPP_32 : tgarle_pkg::BPP_24;
			cmap   = 8'd0;
			id_len = ($urandom_range(0, 24) == 0) ? 8'd255 : 8'($urandom_range(0, 3));
			big    = ($urandom_range(0, 11) == 0);
			w      = big ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 7));
			h      = big ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 5));
			cut    = big || ($urandom_range(0, 9) == 0);
			if (pick < 5) begin
				id_len = 8'($urandom);
				cmap   = 8'($urandom);
				itype  = 8'($urandom);
				depth  = 8'($urandom);
				w      = 16'($urandom);
				h      = 16'($urandom);
				cut    = 1'b1;
			end else if (pick < 10) begin
				cmap = 8'($urandom_range(1, 255));
			end else if (pick < 15) begin
				depth = 8'($urandom);
			end else if (pick < 18) begin
				itype = 8'($urandom);
			end else if (pick < 21) begin
				if ($urandom_range(0, 1))
					w = 16'd0;
				else
					h = 16'd0;
			end
			send_header(id_len, cmap, itype, w, h, depth);
			if (dec_phase == DEC_ID_SKIP)
				repeat (id_len) send_beat(8'($urandom), 1'b0);
			if (dec_phase != DEC_IDLE) begin
				pixels = cut ? $urandom_range(0, 12) : int'(w) * int'(h);
				while (pixels > 0) begin
					if (itype == tgarle_pkg::TYPE_RLE) begin
						if ($urandom_range(0, 1)) begin
							n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128)
								: $urandom_range(1, 4);
							send_beat(8'h80 | 8'(n - 1), 1'b0);
							send_colour($urandom, depth);
						end else begin
							n = $urandom_range(1, 6);
							send_beat(8'(n - 1), 1'b0);
							repeat (n) send_colour($urandom, depth);
						end
					end else begin
						n = 1;
						send_colour($urandom, depth);
					end
					pixels -= n;
				end
				// when cut, may end the file part way through a pixel
				if (cut)
					repeat ($urandom_range(0, 2)) send_beat(8'($urandom), 1'b0);
			end
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3))
					send_beat(8'($urandom), ($urandom_range(0, 9) == 0));
		end
		calm = 1'b0;
	endtask

	initial begin
		clear_decoder();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_bytes();
		test_header_rejects();
		test_empty_images();
		test_raw_image();
		test_rle_packets();
		test_raw_packet_past_end();
		test_restart_and_tall_runs();
		test_random_files();
		in_valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/tgarle_pkg.sv
rtl/tgarle_div.sv
rtl/tgarle_parse.sv
rtl/tgarle_skid.sv
rtl/tga_rle_image_decoder.sv
sim/tb.sv
